@@ hw/rtl/tist_pkg.sv @@
// ----------------------------------------------------------------------------
// tist_pkg
// Shared types and constants for the tracked id status table.
// ----------------------------------------------------------------------------
package tist_pkg;

  localparam int unsigned Entries = 256;
  localparam int unsigned AddrW   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW    = $clog2(Entries + 1);
  localparam int unsigned IdW     = 32;
  localparam int unsigned CksW    = 32;
  localparam int unsigned TotW    = 32;
  localparam int unsigned OpW     = 3;
  localparam int unsigned StW     = 2;

  typedef enum logic [OpW-1:0] {
    OP_INIT     = 3'd0,
    OP_SHUTDOWN = 3'd1,
    OP_REGISTER = 3'd2,
    OP_VERIFY   = 3'd3,
    OP_FAIL     = 3'd4,
    OP_QUERY    = 3'd5,
    OP_STATS    = 3'd6
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_PENDING  = 2'd0,
    ST_VERIFIED = 2'd1,
    ST_FAILED   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_ACT
  } ctrl_state_e;

  // Table memory access from the controller.
  typedef struct packed {
    logic              id_we;
    logic              st_we;
    logic              cks_we;
    logic [AddrW-1:0]  waddr;
    logic [IdW-1:0]    id_wdata;
    logic [StW-1:0]    st_wdata;
    logic [CksW-1:0]   cks_wdata;
    logic [AddrW-1:0]  id_raddr;
    logic [AddrW-1:0]  ent_raddr;
  } mem_req_t;

  typedef struct packed {
    logic [IdW-1:0]  id_rdata;
    logic [StW-1:0]  st_rdata;
    logic [CksW-1:0] cks_rdata;
  } mem_rsp_t;

  typedef struct packed {
    logic            ok;
    logic [IdW-1:0]  new_id;
    logic [StW-1:0]  entry_status;
    logic [CksW-1:0] stored_checksum;
    logic [TotW-1:0] verified_count;
    logic [TotW-1:0] failed_count;
  } result_t;

endpackage

@@ hw/rtl/tist_store.sv @@
// ----------------------------------------------------------------------------
// tist_store
// Slot storage: id, status and checksum memories, registered reads.
// ----------------------------------------------------------------------------
module tist_store (
  input  logic                clk_i,
  input  tist_pkg::mem_req_t  req_i,
  output tist_pkg::mem_rsp_t  rsp_o
);

  logic [tist_pkg::IdW-1:0]  id_mem  [tist_pkg::Entries];
  logic [tist_pkg::StW-1:0]  st_mem  [tist_pkg::Entries];
  logic [tist_pkg::CksW-1:0] cks_mem [tist_pkg::Entries];

  logic [tist_pkg::IdW-1:0]  id_rdata_q;
  logic [tist_pkg::StW-1:0]  st_rdata_q;
  logic [tist_pkg::CksW-1:0] cks_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.id_we) begin
      id_mem[req_i.waddr] <= req_i.id_wdata;
    end
    id_rdata_q <= id_mem[req_i.id_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.st_we) begin
      st_mem[req_i.waddr] <= req_i.st_wdata;
    end
    st_rdata_q <= st_mem[req_i.ent_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.cks_we) begin
      cks_mem[req_i.waddr] <= req_i.cks_wdata;
    end
    cks_rdata_q <= cks_mem[req_i.ent_raddr];
  end

  assign rsp_o.id_rdata  = id_rdata_q;
  assign rsp_o.st_rdata  = st_rdata_q;
  assign rsp_o.cks_rdata = cks_rdata_q;

endmodule

@@ hw/rtl/tist_ctrl.sv @@
// ----------------------------------------------------------------------------
// tist_ctrl
// Operation sequencer: decode, slot scan, read-modify-write of the table.
// ----------------------------------------------------------------------------
module tist_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tist_pkg::OpW-1:0]     op_i,
  input  logic [tist_pkg::IdW-1:0]     entry_id_i,
  input  logic [tist_pkg::CksW-1:0]    checksum_i,
  input  logic                         out_free_i,
  output logic                         res_valid_o,
  output tist_pkg::result_t            res_o,
  output tist_pkg::mem_req_t           mem_req_o,
  input  tist_pkg::mem_rsp_t           mem_rsp_i
);

  tist_pkg::ctrl_state_e state_q, state_d;

  logic [tist_pkg::OpW-1:0]   op_q, op_d;
  logic [tist_pkg::IdW-1:0]   id_q, id_d;
  logic [tist_pkg::CksW-1:0]  cks_q, cks_d;
  logic                       enabled_q, enabled_d;
  logic [tist_pkg::CntW-1:0]  fill_q, fill_d;
  logic [tist_pkg::IdW-1:0]   id_ctr_q, id_ctr_d;
  logic [tist_pkg::TotW-1:0]  vtot_q, vtot_d;
  logic [tist_pkg::TotW-1:0]  ftot_q, ftot_d;
  logic [tist_pkg::CntW-1:0]  idx_q, idx_d;
  logic                       rd_pend_q, rd_pend_d;
  logic [tist_pkg::AddrW-1:0] rd_addr_q, rd_addr_d;

  logic hit;
  logic scan_op;
  logic full;

  assign hit     = rd_pend_q && (mem_rsp_i.id_rdata == id_q);
  assign scan_op = (op_q == tist_pkg::OP_VERIFY) || (op_q == tist_pkg::OP_FAIL) ||
                   (op_q == tist_pkg::OP_QUERY);
  assign full    = (fill_q == tist_pkg::CntW'(tist_pkg::Entries));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tist_pkg::S_IDLE;
      enabled_q <= 1'b0;
      fill_q    <= '0;
      id_ctr_q  <= tist_pkg::IdW'(1);
      vtot_q    <= '0;
      ftot_q    <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      enabled_q <= enabled_d;
      fill_q    <= fill_d;
      id_ctr_q  <= id_ctr_d;
      vtot_q    <= vtot_d;
      ftot_q    <= ftot_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    id_q      <= id_d;
    cks_q     <= cks_d;
    idx_q     <= idx_d;
    rd_addr_q <= rd_addr_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    id_d        = id_q;
    cks_d       = cks_q;
    enabled_d   = enabled_q;
    fill_d      = fill_q;
    id_ctr_d    = id_ctr_q;
    vtot_d      = vtot_q;
    ftot_d      = ftot_q;
    idx_d       = idx_q;
    rd_pend_d   = rd_pend_q;
    rd_addr_d   = rd_addr_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    mem_req_o           = '0;
    mem_req_o.waddr     = rd_addr_q;
    mem_req_o.id_raddr  = idx_q[tist_pkg::AddrW-1:0];
    mem_req_o.ent_raddr = rd_addr_q;

    case (state_q)
      tist_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = op_i;
          id_d    = entry_id_i;
          cks_d   = checksum_i;
          state_d = tist_pkg::S_DECODE;
        end
      end

      tist_pkg::S_DECODE: begin
        if (scan_op && enabled_q) begin
          idx_d     = '0;
          rd_pend_d = 1'b0;
          state_d   = tist_pkg::S_SCAN;
        end else if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = tist_pkg::S_IDLE;
          case (op_q)
            tist_pkg::OP_INIT: begin
              // Clearing the fill count retires every slot at once.
              if (!enabled_q) begin
                fill_d   = '0;
                id_ctr_d = tist_pkg::IdW'(1);
                vtot_d   = '0;
                ftot_d   = '0;
              end
              enabled_d = 1'b1;
              res_o.ok  = 1'b1;
            end
            tist_pkg::OP_SHUTDOWN: begin
              enabled_d = 1'b0;
            end
            tist_pkg::OP_REGISTER: begin
              if (enabled_q && !full) begin
                id_ctr_d            = id_ctr_q + tist_pkg::IdW'(1);
                mem_req_o.id_we     = 1'b1;
                mem_req_o.st_we     = 1'b1;
                mem_req_o.cks_we    = 1'b1;
                mem_req_o.waddr     = fill_q[tist_pkg::AddrW-1:0];
                mem_req_o.id_wdata  = id_ctr_d;
                mem_req_o.st_wdata  = tist_pkg::ST_PENDING;
                mem_req_o.cks_wdata = '0;
                fill_d              = fill_q + tist_pkg::CntW'(1);
                res_o.ok            = 1'b1;
                res_o.new_id        = id_ctr_d;
              end
            end
            tist_pkg::OP_STATS: begin
              res_o.ok             = 1'b1;
              res_o.verified_count = vtot_q;
              res_o.failed_count   = ftot_q;
            end
            default: begin
              // Disabled lookups and the unused code fail with no effect.
            end
          endcase
        end
      end

      tist_pkg::S_SCAN: begin
        rd_pend_d = 1'b0;
        if (hit) begin
          state_d = tist_pkg::S_ACT;
        end else if (idx_q < fill_q) begin
          rd_pend_d = 1'b1;
          rd_addr_d = idx_q[tist_pkg::AddrW-1:0];
          idx_d     = idx_q + tist_pkg::CntW'(1);
        end else if (!rd_pend_q && out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = tist_pkg::S_IDLE;
        end
      end

      tist_pkg::S_ACT: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = tist_pkg::S_IDLE;
          case (op_q)
            tist_pkg::OP_VERIFY: begin
              mem_req_o.st_we     = 1'b1;
              mem_req_o.cks_we    = 1'b1;
              mem_req_o.st_wdata  = tist_pkg::ST_VERIFIED;
              mem_req_o.cks_wdata = cks_q;
              vtot_d              = vtot_q + tist_pkg::TotW'(1);
              res_o.ok            = 1'b1;
            end
            tist_pkg::OP_FAIL: begin
              mem_req_o.st_we    = 1'b1;
              mem_req_o.st_wdata = tist_pkg::ST_FAILED;
              ftot_d             = ftot_q + tist_pkg::TotW'(1);
              res_o.ok           = 1'b1;
            end
            tist_pkg::OP_QUERY: begin
              res_o.ok              = 1'b1;
              res_o.entry_status    = mem_rsp_i.st_rdata;
              res_o.stored_checksum = mem_rsp_i.cks_rdata;
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_d = tist_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/tracked_id_status_table.sv @@
// ----------------------------------------------------------------------------
// tracked_id_status_table
// Table of tracked slots with id allocation, verify/fail marking and query.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. Init, shutdown, register, stats and
// any operation issued while disabled are answered from the decode state,
// which waits until the output register is free. Verify, fail and query
// scan the occupied slots in order, one id memory read per cycle through
// the single read port of the id memory, up to the first match (all occupied
// slots when the id is absent), and answer once the output register is free.
// Slots fill from index 0 upward and are never freed, so a fill count marks
// the occupied slots and init from the disabled state clears the table by
// resetting that count, with no clearing pass. The result sits in an output
// register; a new input beat is taken while it waits.
module tracked_id_status_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input beats.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // [31:0] entry_id, [63:32] checksum_in
  input  logic [2:0]   s_axis_tuser,   // [2:0] op
  // Result beats.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata    // [0] ok, [32:1] new_id,
                                       // [34:33] entry_status,
                                       // [66:35] stored_checksum,
                                       // [98:67] verified_count,
                                       // [130:99] failed_count, [135:131] zero
);

  tist_pkg::mem_req_t mem_req;
  tist_pkg::mem_rsp_t mem_rsp;
  tist_pkg::result_t  res;
  tist_pkg::result_t  res_q;
  logic               res_valid;
  logic               out_valid_q;
  logic               out_free;

  // The result register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || m_axis_tready;

  tist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .entry_id_i  (s_axis_tdata[31:0]),
    .checksum_i  (s_axis_tdata[63:32]),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rsp_i   (mem_rsp)
  );

  tist_store u_store (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

  // Hold the result beat until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the payload only with a new result.
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, res_q.failed_count, res_q.verified_count,
                          res_q.stored_checksum, res_q.entry_status,
                          res_q.new_id, res_q.ok};

endmodule

@@ hw/rtl/tist_checker.sv @@
// ----------------------------------------------------------------------------
// tist_checker
// Port-level checks for the tracked id status table.
// ----------------------------------------------------------------------------
module tist_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [63:0]  s_axis_tdata,
  input logic [2:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Only one operation at a time: no input beat right after another.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an operation is in flight");

  // A failed operation reports nothing else.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[135:1] == 135'd0)
    else $error("failed result carries payload");

  // Status is always a defined code.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[34:33] != 2'd3)
    else $error("undefined status code");

  // Result padding stays zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[135:131] == 5'd0)
    else $error("result padding not zero");

endmodule

bind tracked_id_status_table tist_checker u_tist_checker (.*);

@@ bench/tb_tracked_id_status_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tracked_id_status_table
// Streams op beats into the tracked id status table under random sender gaps
// and receiver stalls, predicts every result from a private copy of the table
// and compares each result beat field by field.
// ----------------------------------------------------------------------------
module tb_tracked_id_status_table;
  import tist_pkg::*;

  // Op code outside the package enum; the block must answer it with ok low.
  localparam logic [OpW-1:0] OP_UNUSED = 3'd7;

  localparam int unsigned StimItems   = 1400;
  localparam int unsigned DrainCycles = 300;   // longer than a full-table scan
  localparam int unsigned IdleLimit   = 4000;  // cycles without any beat

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [IdW-1:0]  entry_id;
    logic [CksW-1:0] checksum;
  } cmd_t;

  // Receiver stall styles, switched at random intervals.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_WAVE
  } rx_mode_e;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata  = '0;    // [31:0] entry_id, [63:32] checksum_in
  logic [2:0]   s_axis_tuser  = '0;    // [2:0] op
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;          // [0] ok, [32:1] new_id,
                                       // [34:33] entry_status,
                                       // [66:35] stored_checksum,
                                       // [98:67] verified_count,
                                       // [130:99] failed_count, [135:131] zero

  tracked_id_status_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Table predictor: own copy of every slot, the id counter and both totals.
  // --------------------------------------------------------------------------
  logic            tbl_active [Entries];
  logic [IdW-1:0]  tbl_id     [Entries];
  status_e         tbl_status [Entries];
  logic [CksW-1:0] tbl_cks    [Entries];
  logic            tbl_enabled;
  logic [IdW-1:0]  id_ctr;
  logic [TotW-1:0] verify_tot;
  logic [TotW-1:0] fail_tot;

  cmd_t    pend_q[$];     // op beats still to be sent
  result_t result_q[$];   // predicted results, oldest first
  int      err_cnt = 0;

  function automatic void table_clear();
    for (int i = 0; i < Entries; i++) begin
      tbl_active[i] = 1'b0;
      tbl_id[i]     = '0;
      tbl_status[i] = ST_PENDING;
      tbl_cks[i]    = '0;
    end
    id_ctr     = 1;
    verify_tot = '0;
    fail_tot   = '0;
  endfunction

  // Lowest-numbered active slot holding this id, or -1.
  function automatic int table_find(logic [IdW-1:0] id);
    for (int i = 0; i < Entries; i++) begin
      if (tbl_active[i] && tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  // Apply one op beat to the table copy and return the result it must give.
  function automatic result_t table_apply(cmd_t c);
    result_t r;
    int      slot;
    r    = '0;
    slot = -1;
    case (c.op)
      OP_INIT: begin
        // Clear only when coming out of the disabled state.
        if (!tbl_enabled) table_clear();
        tbl_enabled = 1'b1;
        r.ok        = 1'b1;
      end
      OP_SHUTDOWN: tbl_enabled = 1'b0;
      OP_REGISTER: begin
        if (tbl_enabled) begin
          for (int i = 0; i < Entries && slot < 0; i++) begin
            if (!tbl_active[i]) slot = i;
          end
          // A full table leaves the id counter alone.
          if (slot >= 0) begin
            id_ctr           = id_ctr + 1;
            tbl_id[slot]     = id_ctr;
            tbl_status[slot] = ST_PENDING;
            tbl_cks[slot]    = '0;
            tbl_active[slot] = 1'b1;
            r.new_id         = id_ctr;
            r.ok             = 1'b1;
          end
        end
      end
      OP_VERIFY: begin
        if (tbl_enabled) slot = table_find(c.entry_id);
        if (slot >= 0) begin
          tbl_cks[slot]    = c.checksum;
          tbl_status[slot] = ST_VERIFIED;
          verify_tot       = verify_tot + 1;
          r.ok             = 1'b1;
        end
      end
      OP_FAIL: begin
        // Keep the stored checksum.
        if (tbl_enabled) slot = table_find(c.entry_id);
        if (slot >= 0) begin
          tbl_status[slot] = ST_FAILED;
          fail_tot         = fail_tot + 1;
          r.ok             = 1'b1;
        end
      end
      OP_QUERY: begin
        if (tbl_enabled) slot = table_find(c.entry_id);
        if (slot >= 0) begin
          r.entry_status    = tbl_status[slot];
          r.stored_checksum = tbl_cks[slot];
          r.ok              = 1'b1;
        end
      end
      OP_STATS: begin
        // Stats answer even while disabled.
        r.verified_count = verify_tot;
        r.failed_count   = fail_tot;
        r.ok             = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation, with a rough mirror of enable and fill level so that
  // most ids hit live slots.
  // --------------------------------------------------------------------------
  logic gen_on   = 1'b0;
  int   gen_fill = 0;

  task automatic queue_cmd(logic [OpW-1:0] op, logic [IdW-1:0] id, logic [CksW-1:0] cks);
    cmd_t c;
    c.op       = op;
    c.entry_id = id;
    c.checksum = cks;
    pend_q.push_back(c);
    case (op)
      OP_INIT: begin
        if (!gen_on) gen_fill = 0;
        gen_on = 1'b1;
      end
      OP_SHUTDOWN: gen_on = 1'b0;
      OP_REGISTER: if (gen_on && gen_fill < Entries) gen_fill++;
      default: ;
    endcase
  endtask

  // Mostly live ids, some just past the last one, a few anywhere in 32 bits.
  function automatic logic [IdW-1:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7 && gen_fill > 0) return $urandom_range(2, gen_fill + 1);
    if (r < 8) return $urandom_range(0, gen_fill + 3);
    return $urandom();
  endfunction

  function automatic logic [CksW-1:0] pick_cks();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  initial begin
    int pick;
    int fills_done;
    fills_done  = 0;
    tbl_enabled = 1'b0;
    table_clear();

    // Directed: disabled behavior, first ids, repeated marks, misses, extremes.
    queue_cmd(OP_STATS,    '0, '0);
    queue_cmd(OP_REGISTER, '0, '0);
    queue_cmd(OP_QUERY,    '0, '1);
    queue_cmd(OP_INIT,     '1, '1);
    queue_cmd(OP_INIT,     '0, '0);           // already enabled: no clear
    queue_cmd(OP_REGISTER, '1, '1);           // first id is 2
    queue_cmd(OP_REGISTER, '0, '0);
    queue_cmd(OP_QUERY,    32'd2, '0);
    queue_cmd(OP_VERIFY,   32'd2, '1);
    queue_cmd(OP_VERIFY,   32'd2, 32'h0000_0000); // overwrite checksum
    queue_cmd(OP_QUERY,    32'd2, '1);
    queue_cmd(OP_VERIFY,   32'd3, 32'hA5A5_5A5A);
    queue_cmd(OP_FAIL,     32'd3, '1);
    queue_cmd(OP_FAIL,     32'd3, '0);        // counts again, keeps checksum
    queue_cmd(OP_QUERY,    32'd3, '0);
    queue_cmd(OP_QUERY,    '1, '1);           // absent id
    queue_cmd(OP_VERIFY,   '0, '1);
    queue_cmd(OP_UNUSED,   '1, '1);
    queue_cmd(OP_STATS,    '1, '1);
    queue_cmd(OP_SHUTDOWN, '0, '0);
    queue_cmd(OP_STATS,    '0, '0);           // totals survive shutdown
    queue_cmd(OP_VERIFY,   32'd2, '1);        // refused while disabled
    queue_cmd(OP_INIT,     '0, '0);           // clears
    queue_cmd(OP_QUERY,    32'd2, '0);
    queue_cmd(OP_STATS,    '0, '0);

    // Random: mostly live traffic on a small table, short disabled spells,
    // and two runs that fill the table and knock on it when full.
    while (pend_q.size() < StimItems) begin
      if (gen_on && fills_done < 2 && pend_q.size() > 350 + 450 * fills_done) begin
        repeat (Entries - gen_fill + 3) queue_cmd(OP_REGISTER, $urandom(), pick_cks());
        fills_done++;
      end else if (!gen_on) begin
        if ($urandom_range(0, 9) < 3) queue_cmd(OP_INIT, pick_id(), pick_cks());
        else queue_cmd(OpW'($urandom_range(1, 7)), pick_id(), pick_cks());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 26)      queue_cmd(OP_REGISTER, pick_id(), pick_cks());
        else if (pick < 46) queue_cmd(OP_VERIFY, pick_id(), pick_cks());
        else if (pick < 58) queue_cmd(OP_FAIL, pick_id(), pick_cks());
        else if (pick < 78) queue_cmd(OP_QUERY, pick_id(), pick_cks());
        else if (pick < 86) queue_cmd(OP_STATS, pick_id(), pick_cks());
        else if (pick < 89) queue_cmd(OP_INIT, pick_id(), pick_cks());
        else if (pick < 92) queue_cmd(OP_SHUTDOWN, pick_id(), pick_cks());
        else if (pick < 94) queue_cmd(OP_UNUSED, pick_id(), pick_cks());
        else queue_cmd(OpW'($urandom_range(0, 7)), $urandom(), $urandom());
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold until every beat is sent and every result has come back.
    while (pend_q.size() != 0 || result_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of beats with random gaps. Predict at the accepting edge.
  // --------------------------------------------------------------------------
  int   burst_left;
  int   gap_left;
  logic holding;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      burst_left    <= 1;
      gap_left      <= 0;
    end else begin
      holding = s_axis_tvalid && !s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        result_q.push_back(table_apply(pend_q.pop_front()));
      end
      // A beat not yet taken stays on the bus untouched.
      if (!holding) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {pend_q[0].checksum, pend_q[0].entry_id};
          s_axis_tuser  <= pend_q[0].op;
          // Close the burst on its last beat and draw the next gap and length.
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: switch stall style at random intervals.
  // --------------------------------------------------------------------------
  rx_mode_e rx_mode;
  int       rx_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_mode       <= RX_OPEN;
      rx_left       <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        rx_left <= $urandom_range(16, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:  m_axis_tready <= 1'b1;
        RX_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:  m_axis_tready <= rx_left[2];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest prediction.
  // --------------------------------------------------------------------------
  result_t want;

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $display("%0t: result beat with none expected, expected none, actual %h",
                 $time, m_axis_tdata);
        err_cnt++;
      end else begin
        want = result_q.pop_front();
        check_field("ok", 32'(want.ok), 32'(m_axis_tdata[0]));
        check_field("new_id", want.new_id, m_axis_tdata[32:1]);
        check_field("entry_status", 32'(want.entry_status), 32'(m_axis_tdata[34:33]));
        check_field("stored_checksum", want.stored_checksum, m_axis_tdata[66:35]);
        check_field("verified_count", want.verified_count, m_axis_tdata[98:67]);
        check_field("failed_count", want.failed_count, m_axis_tdata[130:99]);
        check_field("pad", '0, 32'(m_axis_tdata[135:131]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: drop the run if no beat moves on either side for too long.
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      if (idle_cycles >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
